// File: hw/rtl/iva_pkg.sv
`default_nettype none
package iva_pkg;

  localparam int LANES  = 4;
  localparam int LANE_W = 32;
  localparam int SEL_W  = 2;
  localparam int SH_W   = 5;

  typedef logic [LANE_W-1:0] lane_t;

  typedef enum logic [4:0] {
    OP_PASS       = 5'd0,
    OP_ZERO       = 5'd1,
    OP_SPLAT      = 5'd2,
    OP_BOOL       = 5'd3,
    OP_ABS        = 5'd4,
    OP_NEG        = 5'd5,
    OP_NOT        = 5'd6,
    OP_ADD        = 5'd7,
    OP_SUB        = 5'd8,
    OP_MUL        = 5'd9,
    OP_AND        = 5'd10,
    OP_OR         = 5'd11,
    OP_XOR        = 5'd12,
    OP_MIN        = 5'd13,
    OP_MAX        = 5'd14,
    OP_LT         = 5'd15,
    OP_EQ         = 5'd16,
    OP_GT         = 5'd17,
    OP_SHUFFLE    = 5'd18,
    OP_SHUFFLEMIX = 5'd19,
    OP_SHL        = 5'd20,
    OP_SHRL       = 5'd21,
    OP_SHRA       = 5'd22,
    OP_SELECT     = 5'd23,
    OP_SIGNMASK   = 5'd24
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [SH_W-1:0] sh;
  } lane_ctrl_t;

  typedef struct packed {
    logic [2*LANE_W-1:0] r_xy;
    logic [2*LANE_W-1:0] r_zw;
    logic [LANES-1:0]    sign_bits;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/iva_lane.sv
`default_nettype none
module iva_lane
  import iva_pkg::*;
(
  input  wire lane_ctrl_t ctrl,
  input  wire lane_t      a,
  input  wire lane_t      b,
  input  wire lane_t      c,
  input  wire lane_t      splat,
  input  wire lane_t      shuf,
  output lane_t           r
);

  lane_t neg_a;
  lane_t prod;
  logic  a_lt_b;
  logic  b_lt_a;

  assign neg_a  = lane_t'(0) - a;
  assign prod   = a * b;
  assign a_lt_b = $signed(a) < $signed(b);
  assign b_lt_a = $signed(b) < $signed(a);

  always_comb begin
    case (ctrl.op)
      OP_PASS:       r = a;
      OP_ZERO:       r = '0;
      OP_SPLAT:      r = splat;
      OP_BOOL:       r = (a != '0) ? '1 : '0;
      OP_ABS:        r = a[LANE_W-1] ? neg_a : a;
      OP_NEG:        r = neg_a;
      OP_NOT:        r = ~a;
      OP_ADD:        r = a + b;
      OP_SUB:        r = a - b;
      OP_MUL:        r = prod;
      OP_AND:        r = a & b;
      OP_OR:         r = a | b;
      OP_XOR:        r = a ^ b;
      OP_MIN:        r = a_lt_b ? a : b;
      OP_MAX:        r = b_lt_a ? a : b;
      OP_LT:         r = a_lt_b ? '1 : '0;
      OP_EQ:         r = (a == b) ? '1 : '0;
      OP_GT:         r = b_lt_a ? '1 : '0;
      OP_SHUFFLE:    r = shuf;
      OP_SHUFFLEMIX: r = shuf;
      OP_SHL:        r = a << ctrl.sh;
      OP_SHRL:       r = a >> ctrl.sh;
      OP_SHRA:       r = lane_t'($signed(a) >>> ctrl.sh);
      OP_SELECT:     r = (a & b) | (~a & c);
      default:       r = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/iva_merge.sv
`default_nettype none
module iva_merge
  import iva_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire lane_t           lane_r [LANES],
  input  wire [LANES-1:0]      signs,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [2*LANE_W-1:0]  r_xy,
  output logic [2*LANE_W-1:0]  r_zw,
  output logic [LANES-1:0]     sign_bits
);

  result_t packed_res;
  result_t main_res;
  result_t skid_res;
  logic    skid_valid;
  logic    accept;
  logic    main_free;

  // lanes x and y in the first word, z and w in the second
  assign packed_res.r_xy      = {lane_r[1], lane_r[0]};
  assign packed_res.r_zw      = {lane_r[3], lane_r[2]};
  assign packed_res.sign_bits = signs;

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign main_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        main_res <= skid_res;
      end else if (accept) begin
        main_res <= packed_res;
      end
    end else if (accept) begin
      skid_res <= packed_res;
    end
  end

  assign r_xy      = main_res.r_xy;
  assign r_zw      = main_res.r_zw;
  assign sign_bits = main_res.sign_bits;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a transfer while output register is empty");

  a_stalled_accept_to_skid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && accept) |=> skid_valid)
    else $error("transfer taken under stall did not land in skid");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (out_valid && !skid_valid))
    else $error("skid did not move to output register");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_stall) |=> (skid_valid && $stable(skid_res)))
    else $error("skid content changed while stalled");

endmodule
`default_nettype wire

// File: hw/rtl/int32x4_vector_alu.sv
// int32x4_vector_alu: four-lane 32-bit signed integer vector ALU
//
// input channel: in_valid / in_stall with operation, a_xy..c_zw and immediate;
// a transfer happens on a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with r_xy, r_zw and sign_bits;
// a transfer happens on a rising edge with out_valid high and out_stall low
//
// each lane has its own adder, comparator, shifter and 32x32 multiplier; the
// operation is worked out in the cycle of the input transfer and the packed
// result is registered, in the skid register if the output register is stalled
// throughput is one item per cycle unless stalled, set by the single registered lane stage
//
// the output side has a result register and a one-entry skid register; while
// the receiver stalls one further item is still taken, and in_stall rises only
// once the skid register is full
// reset (rst, synchronous) empties both registers; no other state is kept
`default_nettype none
module int32x4_vector_alu
  import iva_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [4:0]   operation,
  input  wire [63:0]  a_xy,
  input  wire [63:0]  a_zw,
  input  wire [63:0]  b_xy,
  input  wire [63:0]  b_zw,
  input  wire [63:0]  c_xy,
  input  wire [63:0]  c_zw,
  input  wire [7:0]   immediate,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] r_xy,
  output logic [63:0] r_zw,
  output logic [3:0]  sign_bits
);

  lane_t            a_l [LANES];
  lane_t            b_l [LANES];
  lane_t            c_l [LANES];
  lane_t            shuf_l [LANES];
  lane_t            r_l [LANES];
  logic [LANES-1:0] signs;
  lane_ctrl_t       ctrl;

  assign a_l[0] = a_xy[LANE_W-1:0];
  assign a_l[1] = a_xy[2*LANE_W-1:LANE_W];
  assign a_l[2] = a_zw[LANE_W-1:0];
  assign a_l[3] = a_zw[2*LANE_W-1:LANE_W];
  assign b_l[0] = b_xy[LANE_W-1:0];
  assign b_l[1] = b_xy[2*LANE_W-1:LANE_W];
  assign b_l[2] = b_zw[LANE_W-1:0];
  assign b_l[3] = b_zw[2*LANE_W-1:LANE_W];
  assign c_l[0] = c_xy[LANE_W-1:0];
  assign c_l[1] = c_xy[2*LANE_W-1:LANE_W];
  assign c_l[2] = c_zw[LANE_W-1:0];
  assign c_l[3] = c_zw[2*LANE_W-1:LANE_W];

  assign ctrl.op = op_t'(operation);
  assign ctrl.sh = immediate[SH_W-1:0];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [SEL_W-1:0] sel;

    assign sel      = immediate[SEL_W*i +: SEL_W];
    assign signs[i] = a_l[i][LANE_W-1];
    // upper lanes of shuffle-mix come from b
    assign shuf_l[i] = (ctrl.op == OP_SHUFFLEMIX && i >= LANES / 2) ? b_l[sel] : a_l[sel];

    iva_lane u_lane (
      .ctrl  (ctrl),
      .a     (a_l[i]),
      .b     (b_l[i]),
      .c     (c_l[i]),
      .splat (a_l[0]),
      .shuf  (shuf_l[i]),
      .r     (r_l[i])
    );
  end

  iva_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .lane_r    (r_l),
    .signs     (signs),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .r_xy      (r_xy),
    .r_zw      (r_zw),
    .sign_bits (sign_bits)
  );

endmodule
`default_nettype wire

// File: tb/int32x4_vector_alu_tb.sv
`timescale 1ns / 1ps
module int32x4_vector_alu_tb;
  import iva_pkg::*;

  localparam logic [4:0] OP_UNUSED_TOP = 5'd31;
  localparam int N_DIRECTED = 26;
  localparam int N_RANDOM = 1075;
  localparam int IDLE_OFF_AT = N_RANDOM - 150;
  localparam int PRESSURE_AT = 400;
  localparam int PRESSURE_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [4:0]  op;
    logic [63:0] a_xy;
    logic [63:0] a_zw;
    logic [63:0] b_xy;
    logic [63:0] b_zw;
    logic [63:0] c_xy;
    logic [63:0] c_zw;
    logic [7:0]  imm;
  } alu_req_t;

  typedef struct packed {
    alu_req_t req;
    logic     known;
    result_t  want;
  } vec_row_t;

  localparam result_t NO_CHECK = '0;

  localparam vec_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{'{OP_PASS, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 8'h00}, 1'b1,
      '{64'h0, 64'h0, 4'h0}},
    '{'{OP_ZERO, '1, '1, '1, '1, '1, '1, 8'hff}, 1'b1,
      '{64'h0, 64'h0, 4'hf}},
    '{'{OP_SPLAT, 64'h00000001_80000000, 64'h00000003_00000002,
        64'h0, 64'h0, 64'h0, 64'h0, 8'h00}, 1'b0, NO_CHECK},
    '{'{OP_BOOL, 64'h00000000_00000001, 64'h00000000_80000000,
        64'h0, 64'h0, 64'h0, 64'h0, 8'h00}, 1'b0, NO_CHECK},
    '{'{OP_ABS, 64'h80000000_80000000, 64'h80000000_80000000,
        64'h0, 64'h0, 64'h0, 64'h0, 8'h00}, 1'b1,
      '{64'h80000000_80000000, 64'h80000000_80000000, 4'hf}},
    '{'{OP_NEG, 64'h80000000_7fffffff, 64'h00000001_00000000,
        64'h0, 64'h0, 64'h0, 64'h0, 8'h00}, 1'b0, NO_CHECK},
    '{'{OP_NOT, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 8'h00}, 1'b1,
      '{'1, '1, 4'h0}},
    '{'{OP_ADD, 64'h7fffffff_ffffffff, 64'h80000000_00000000,
        64'h00000001_00000001, 64'hffffffff_ffffffff, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_SUB, 64'h7fffffff_ffffffff, 64'h80000000_00000000,
        64'h00000001_00000001, 64'hffffffff_ffffffff, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_MUL, 64'h7fffffff_ffffffff, 64'h00010000_80000000,
        64'h00000002_ffffffff, 64'h00010000_ffffffff, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_AND, 64'hf0f0f0f0_ff00ff00, 64'h12345678_aaaaaaaa,
        64'h0ff00ff0_0f0f0f0f, 64'h87654321_55555555, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_OR, 64'hf0f0f0f0_ff00ff00, 64'h12345678_aaaaaaaa,
        64'h0ff00ff0_0f0f0f0f, 64'h87654321_55555555, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_XOR, 64'hf0f0f0f0_ff00ff00, 64'h12345678_aaaaaaaa,
        64'h0ff00ff0_0f0f0f0f, 64'h87654321_55555555, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_MIN, 64'h7fffffff_80000000, 64'h00000000_ffffffff,
        64'h80000000_7fffffff, 64'hffffffff_00000000, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_MAX, 64'h7fffffff_80000000, 64'h00000000_ffffffff,
        64'h80000000_7fffffff, 64'hffffffff_00000000, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_LT, 64'h7fffffff_80000000, 64'h00000000_ffffffff,
        64'h80000000_7fffffff, 64'hffffffff_00000000, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_EQ, 64'h7fffffff_80000000, 64'h00000005_ffffffff,
        64'h7fffffff_7fffffff, 64'h00000005_00000000, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_GT, 64'h7fffffff_80000000, 64'h00000000_ffffffff,
        64'h80000000_7fffffff, 64'hffffffff_00000000, 64'h0, 64'h0, 8'h00},
      1'b0, NO_CHECK},
    '{'{OP_SHUFFLE, 64'h00000002_00000001, 64'h00000004_00000003,
        64'h0, 64'h0, 64'h0, 64'h0, 8'h1b}, 1'b0, NO_CHECK},
    '{'{OP_SHUFFLEMIX, 64'h00000002_00000001, 64'h00000004_00000003,
        64'h00000006_00000005, 64'h00000008_00000007, 64'h0, 64'h0, 8'h4e},
      1'b0, NO_CHECK},
    '{'{OP_SHL, 64'h00000001_ffffffff, 64'h80000000_00000003,
        64'h0, 64'h0, 64'h0, 64'h0, 8'hff}, 1'b0, NO_CHECK},
    '{'{OP_SHRL, 64'h00000001_ffffffff, 64'h80000000_00000003,
        64'h0, 64'h0, 64'h0, 64'h0, 8'he1}, 1'b0, NO_CHECK},
    '{'{OP_SHRA, 64'h00000001_ffffffff, 64'h80000000_00000003,
        64'h0, 64'h0, 64'h0, 64'h0, 8'h1f}, 1'b0, NO_CHECK},
    '{'{OP_SELECT, 64'hffff0000_00000000, 64'h0f0f0f0f_ffffffff,
        64'h12345678_9abcdef0, 64'h13579bdf_2468ace0,
        64'hfedcba98_76543210, 64'h0badcafe_5a5a5a5a, 8'h00}, 1'b0, NO_CHECK},
    '{'{OP_SIGNMASK, 64'h00000000_80000000, 64'hffffffff_00000001,
        '1, '1, '1, '1, 8'hff}, 1'b1,
      '{64'h0, 64'h0, 4'b1001}},
    '{'{OP_UNUSED_TOP, '1, '1, '1, '1, '1, '1, 8'hff}, 1'b1,
      '{64'h0, 64'h0, 4'hf}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  operation = '0;
  logic [63:0] a_xy = '0;
  logic [63:0] a_zw = '0;
  logic [63:0] b_xy = '0;
  logic [63:0] b_zw = '0;
  logic [63:0] c_xy = '0;
  logic [63:0] c_zw = '0;
  logic [7:0]  immediate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] r_xy;
  logic [63:0] r_zw;
  logic [3:0]  sign_bits;

  result_t predicted_vectors[$];
  int      errors = 0;
  bit      idling = 1'b1;

  int32x4_vector_alu uut (.*);

  initial forever #2 clk = ~clk;

  function automatic result_t vector_alu_result(input alu_req_t req);
    lane_t           a [LANES];
    lane_t           b [LANES];
    lane_t           c [LANES];
    lane_t           r [LANES];
    logic [SH_W-1:0] sh;
    logic [SEL_W-1:0] pick;
    result_t         res;
    int              i;
    res = '0;
    {a[1], a[0]} = req.a_xy;
    {a[3], a[2]} = req.a_zw;
    {b[1], b[0]} = req.b_xy;
    {b[3], b[2]} = req.b_zw;
    {c[1], c[0]} = req.c_xy;
    {c[3], c[2]} = req.c_zw;
    sh = req.imm[SH_W-1:0];
    for (i = 0; i < LANES; i++) begin
      pick = req.imm[SEL_W*i +: SEL_W];
      case (op_t'(req.op))
        OP_PASS:       r[i] = a[i];
        OP_ZERO:       r[i] = '0;
        OP_SPLAT:      r[i] = a[0];
        OP_BOOL:       r[i] = (a[i] != '0) ? '1 : '0;
        OP_ABS:        r[i] = a[i][LANE_W-1] ? -a[i] : a[i];
        OP_NEG:        r[i] = -a[i];
        OP_NOT:        r[i] = ~a[i];
        OP_ADD:        r[i] = a[i] + b[i];
        OP_SUB:        r[i] = a[i] - b[i];
        OP_MUL:        r[i] = a[i] * b[i];
        OP_AND:        r[i] = a[i] & b[i];
        OP_OR:         r[i] = a[i] | b[i];
        OP_XOR:        r[i] = a[i] ^ b[i];
        OP_MIN:        r[i] = ($signed(a[i]) < $signed(b[i])) ? a[i] : b[i];
        OP_MAX:        r[i] = ($signed(b[i]) < $signed(a[i])) ? a[i] : b[i];
        OP_LT:         r[i] = ($signed(a[i]) < $signed(b[i])) ? '1 : '0;
        OP_EQ:         r[i] = (a[i] == b[i]) ? '1 : '0;
        OP_GT:         r[i] = ($signed(b[i]) < $signed(a[i])) ? '1 : '0;
        OP_SHUFFLE:    r[i] = a[pick];
        OP_SHUFFLEMIX: r[i] = (i < 2) ? a[pick] : b[pick];
        OP_SHL:        r[i] = a[i] << sh;
        OP_SHRL:       r[i] = a[i] >> sh;
        OP_SHRA:       r[i] = lane_t'($signed(a[i]) >>> sh);
        OP_SELECT:     r[i] = (a[i] & b[i]) | (~a[i] & c[i]);
        default:       r[i] = '0;
      endcase
      res.sign_bits[i] = a[i][LANE_W-1];
    end
    res.r_xy = {r[1], r[0]};
    res.r_zw = {r[3], r[2]};
    return res;
  endfunction

  function automatic lane_t pick_lane();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return 32'h8000_0000;
      4:       return 32'h7fff_ffff;
      default: return lane_t'($urandom);
    endcase
  endfunction

  task automatic issue_instruction(input alu_req_t req, input result_t want);
    int gap;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= req.op;
    a_xy      <= req.a_xy;
    a_zw      <= req.a_zw;
    b_xy      <= req.b_xy;
    b_zw      <= req.b_zw;
    c_xy      <= req.c_xy;
    c_zw      <= req.c_zw;
    immediate <= req.imm;
    do @(posedge clk); while (in_stall);
    predicted_vectors.push_back(want);
  endtask

  initial begin : sender
    int       n;
    int       l;
    vec_row_t row;
    alu_req_t req;
    lane_t    av [LANES];
    lane_t    bv [LANES];
    lane_t    cv [LANES];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (n = 0; n < N_DIRECTED; n++) begin
      row = DIRECTED_ROWS[n];
      issue_instruction(row.req, row.known ? row.want : vector_alu_result(row.req));
    end
    for (n = 0; n < N_RANDOM; n++) begin
      if (n == IDLE_OFF_AT)
        idling = 1'b0;
      if ($urandom_range(0, 9) == 0)
        req.op = 5'($urandom_range(OP_SIGNMASK + 1, OP_UNUSED_TOP));
      else
        req.op = 5'($urandom_range(OP_PASS, OP_SIGNMASK));
      for (l = 0; l < LANES; l++) begin
        av[l] = pick_lane();
        bv[l] = ($urandom_range(0, 3) == 0) ? av[l] : pick_lane();
        cv[l] = pick_lane();
      end
      req.a_xy = {av[1], av[0]};
      req.a_zw = {av[3], av[2]};
      req.b_xy = {bv[1], bv[0]};
      req.b_zw = {bv[3], bv[2]};
      req.c_xy = {cv[1], cv[0]};
      req.c_zw = {cv[3], cv[2]};
      req.imm  = 8'($urandom);
      issue_instruction(req, vector_alu_result(req));
    end
    in_valid <= 1'b0;
    while (predicted_vectors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("int32x4_vector_alu_tb OK");
    else
      $display("int32x4_vector_alu_tb NOT OK");
    $finish;
  end

  // one long hold-off fills the result and skid registers; short random stalls come while idling
  initial begin : receiver
    int stall_left;
    int cycle_count;
    stall_left  = 0;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count == PRESSURE_AT)
        stall_left = PRESSURE_CYCLES;
      else if (stall_left == 0 && idling && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 7);
      out_stall <= (stall_left != 0);
      if (stall_left != 0)
        stall_left--;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_vectors.size() == 0) begin
        errors++;
        $display("%0t: transfer with nothing expected, r_xy %h r_zw %h sign_bits %h",
                 $time, r_xy, r_zw, sign_bits);
      end else begin
        want = predicted_vectors.pop_front();
        if (r_xy !== want.r_xy) begin
          errors++;
          $display("%0t: r_xy expected %h, got %h", $time, want.r_xy, r_xy);
        end
        if (r_zw !== want.r_zw) begin
          errors++;
          $display("%0t: r_zw expected %h, got %h", $time, want.r_zw, r_zw);
        end
        if (sign_bits !== want.sign_bits) begin
          errors++;
          $display("%0t: sign_bits expected %h, got %h", $time, want.sign_bits, sign_bits);
        end
      end
    end
  end

  always @(posedge clk) begin
    int quiet;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("int32x4_vector_alu_tb NOT OK");
        $finish;
      end
    end
  end

endmodule
